// ===== rtl/ubfc_pkg.sv =====
// Shared types and constants for the URL byte field classifier.
`timescale 1ns / 1ps
package ubfc_pkg;

  // Parser phase
  typedef enum logic [3:0] {
    PH_SCHEME   = 4'd0,
    PH_SLASH1   = 4'd1,
    PH_SLASH2   = 4'd2,
    PH_USERHOST = 4'd3,
    PH_PASSWORD = 4'd4,
    PH_HOST     = 4'd5,
    PH_PORTPASS = 4'd6,
    PH_PORT     = 4'd7,
    PH_PATH     = 4'd8,
    PH_QUERY    = 4'd9,
    PH_FRAG     = 4'd10
  } ubfc_phase_t;

  // Part tags on each result
  localparam logic [3:0] PART_SCHEME     = 4'd0;
  localparam logic [3:0] PART_DELIM      = 4'd1;
  localparam logic [3:0] PART_USERHOST   = 4'd2;
  localparam logic [3:0] PART_USER       = 4'd3;
  localparam logic [3:0] PART_PASSWORD   = 4'd4;
  localparam logic [3:0] PART_HOST       = 4'd5;
  localparam logic [3:0] PART_PORTPASS   = 4'd6;
  localparam logic [3:0] PART_PORT       = 4'd7;
  localparam logic [3:0] PART_PATH       = 4'd8;
  localparam logic [3:0] PART_QUERY      = 4'd9;
  localparam logic [3:0] PART_FRAG       = 4'd10;

  // Resolution codes for pending runs
  localparam logic [2:0] RES_NONE      = 3'd0;
  localparam logic [2:0] RES_USER      = 3'd1;
  localparam logic [2:0] RES_HOST      = 3'd2;
  localparam logic [2:0] RES_HOST_PORT = 3'd3;
  localparam logic [2:0] RES_USER_PASS = 3'd4;

  // Scheme matcher progress
  localparam logic [2:0] MATCH_DONE = 3'd5;
  localparam logic [2:0] MATCH_DEAD = 3'd7;

  localparam logic [15:0] PORT_HTTP  = 16'd80;
  localparam logic [15:0] PORT_HTTPS = 16'd443;
  localparam logic [15:0] PORT_MAX   = 16'hFFFF;

  typedef struct packed {
    ubfc_phase_t phase;
    logic        valid;
    logic [2:0]  match;
    logic        pend_host;
    logic        pend_digits;
    logic        host_nonempty;
    logic [15:0] port_accum;
    logic        port_given;
  } ubfc_state_t;

  typedef struct packed {
    logic [3:0]  part;
    logic [2:0]  res;
    logic        ok;
    logic [15:0] port;
    logic        sec;
  } ubfc_result_t;

  localparam ubfc_state_t STATE_RESET = '{
    phase:         PH_SCHEME,
    valid:         1'b1,
    match:         3'd0,
    pend_host:     1'b0,
    pend_digits:   1'b0,
    host_nonempty: 1'b0,
    port_accum:    16'd0,
    port_given:    1'b0
  };

endpackage

// ===== rtl/ubfc_step.sv =====
// Per-byte classification: next parser state and the result for one byte.
`timescale 1ns / 1ps
module ubfc_step (
  input  ubfc_pkg::ubfc_state_t  st,
  input  logic [7:0]             c,
  input  logic                   last,
  output ubfc_pkg::ubfc_state_t  st_next,
  output ubfc_pkg::ubfc_result_t result
);
  import ubfc_pkg::*;

  function automatic logic is_digit(input logic [7:0] ch);
    return ch inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alnum(input logic [7:0] ch);
    return ch inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic is_unres(input logic [7:0] ch);
    return is_alnum(ch) || (ch inside {8'h2D, 8'h2E, 8'h5F, 8'h7E});
  endfunction

  // Letters of "https" by matcher position
  function automatic logic [7:0] secure_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h68;
      3'd1:    ch = 8'h74;
      3'd2:    ch = 8'h74;
      3'd3:    ch = 8'h70;
      3'd4:    ch = 8'h73;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_AT      = 8'h40;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_QMARK   = 8'h3F;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;

  logic [19:0]  digit_sum;
  logic [15:0]  digit_sat;
  ubfc_state_t  nx;
  logic [3:0]   part;
  logic [2:0]   res;
  logic         err;
  logic         fin;
  logic         sec;
  logic [15:0]  port;

  // Decimal accumulate with saturation; a digit's value is its low nibble
  assign digit_sum = {4'd0, st.port_accum} * 20'd10 + {16'd0, c[3:0]};
  assign digit_sat = (|digit_sum[19:16]) ? PORT_MAX : digit_sum[15:0];

  always_comb begin
    nx   = st;
    part = PART_SCHEME;
    res  = RES_NONE;
    err  = 1'b0;

    // Advance the parser while the URL is still valid
    if (st.valid) begin
      case (st.phase)
        PH_SCHEME: begin
          if (is_alnum(c) || c == CH_PLUS || c == CH_MINUS || c == CH_DOT) begin
            part = PART_SCHEME;
            if (st.match < MATCH_DONE && c == secure_char(st.match)) begin
              nx.match = st.match + 3'd1;
            end else begin
              nx.match = MATCH_DEAD;
            end
          end else if (c == CH_COLON) begin
            part = PART_DELIM;
            nx.phase = PH_SLASH1;
          end else begin
            err = 1'b1;
          end
        end
        PH_SLASH1: begin
          if (c == CH_SLASH) begin
            part = PART_DELIM;
            nx.phase = PH_SLASH2;
          end else if (is_alnum(c)) begin
            part = PART_USERHOST;
            nx.pend_host = 1'b1;
            nx.phase = PH_USERHOST;
          end else begin
            err = 1'b1;
          end
        end
        PH_SLASH2: begin
          if (c == CH_SLASH) begin
            part = PART_DELIM;
            nx.phase = PH_USERHOST;
          end else begin
            err = 1'b1;
          end
        end
        PH_USERHOST: begin
          if (is_unres(c) || c == CH_PERCENT) begin
            part = PART_USERHOST;
            nx.pend_host = 1'b1;
          end else if (c == CH_COLON) begin
            part = PART_DELIM;
            nx.phase = PH_PORTPASS;
          end else if (c == CH_AT) begin
            part = PART_DELIM;
            res = RES_USER;
            nx.pend_host = 1'b0;
            nx.phase = PH_HOST;
          end else if (c == CH_SLASH) begin
            part = PART_PATH;
            res = RES_HOST;
            nx.pend_host = 1'b0;
            nx.phase = PH_PATH;
          end else begin
            err = 1'b1;
          end
        end
        PH_PASSWORD: begin
          if (is_alnum(c) || c == CH_PERCENT) begin
            part = PART_PASSWORD;
          end else if (c == CH_AT) begin
            part = PART_DELIM;
            nx.phase = PH_HOST;
          end else begin
            err = 1'b1;
          end
        end
        PH_HOST: begin
          if (c == CH_LBRACK && !st.host_nonempty) begin
            err = 1'b1;
          end else if (is_unres(c) || c == CH_PERCENT) begin
            part = PART_HOST;
            nx.host_nonempty = 1'b1;
          end else if (c == CH_COLON) begin
            part = PART_DELIM;
            nx.phase = PH_PORT;
          end else if (c == CH_SLASH) begin
            part = PART_PATH;
            nx.phase = PH_PATH;
          end else begin
            err = 1'b1;
          end
        end
        PH_PORTPASS: begin
          if (is_digit(c)) begin
            part = PART_PORTPASS;
            nx.port_accum = digit_sat;
            nx.pend_digits = 1'b1;
          end else if (c == CH_SLASH) begin
            part = PART_PATH;
            res = RES_HOST_PORT;
            nx.port_given = st.pend_digits;
            nx.pend_digits = 1'b0;
            nx.pend_host = 1'b0;
            nx.phase = PH_PATH;
          end else if (is_alnum(c) || c == CH_PERCENT) begin
            part = PART_PASSWORD;
            res = RES_USER_PASS;
            nx.pend_digits = 1'b0;
            nx.pend_host = 1'b0;
            nx.port_accum = 16'd0;
            nx.phase = PH_PASSWORD;
          end else begin
            err = 1'b1;
          end
        end
        PH_PORT: begin
          if (is_digit(c)) begin
            part = PART_PORT;
            nx.port_accum = digit_sat;
            nx.pend_digits = 1'b1;
          end else if (c == CH_SLASH) begin
            part = PART_PATH;
            nx.port_given = st.pend_digits;
            nx.pend_digits = 1'b0;
            nx.phase = PH_PATH;
          end else begin
            err = 1'b1;
          end
        end
        PH_PATH: begin
          if (c == CH_HASH) begin
            part = PART_DELIM;
            nx.phase = PH_FRAG;
          end else if (c == CH_QMARK) begin
            part = PART_DELIM;
            nx.phase = PH_QUERY;
          end else begin
            part = PART_PATH;
          end
        end
        PH_QUERY: begin
          if (c == CH_HASH) begin
            part = PART_DELIM;
            nx.phase = PH_FRAG;
          end else if (c == CH_QMARK) begin
            part = PART_DELIM;
          end else begin
            part = PART_QUERY;
          end
        end
        PH_FRAG: begin
          part = PART_FRAG;
        end
        default: begin
          err = 1'b1;
        end
      endcase
      if (err) begin
        nx.valid = 1'b0;
      end
    end

    // Settle open runs on the last byte; digits still open are an error
    if (last && nx.valid) begin
      if (nx.pend_digits) begin
        nx.valid = 1'b0;
      end else if (nx.phase == PH_USERHOST && nx.pend_host) begin
        res = RES_HOST;
      end else if (nx.phase == PH_PORTPASS && nx.pend_host) begin
        res = RES_HOST_PORT;
      end
    end

    if (!nx.valid) begin
      part = PART_SCHEME;
      res  = RES_NONE;
    end

    // Final report: port and scheme only on a valid last byte
    fin  = last && nx.valid;
    sec  = fin && (nx.match == MATCH_DONE);
    port = 16'd0;
    if (fin) begin
      if (nx.port_given) begin
        port = nx.port_accum;
      end else if (sec) begin
        port = PORT_HTTPS;
      end else begin
        port = PORT_HTTP;
      end
    end

    result.part = part;
    result.res  = res;
    result.ok   = nx.valid;
    result.port = port;
    result.sec  = sec;

    // Start over for the next URL
    st_next = last ? STATE_RESET : nx;
  end

endmodule

// ===== rtl/url_byte_field_classifier.sv =====
// Two register stages (input register, then result register); a beat moves on
// once the result register is free. The next parser state is combinational.
// Throughput: one byte per cycle unless the output stalls.
// Reset (rst, synchronous): clears both stages and returns the parser to the
// scheme phase with the URL marked valid.
`timescale 1ns / 1ps
module url_byte_field_classifier (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_in,
  input  logic        end_of_url,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  char_out,
  output logic [3:0]  part,
  output logic [2:0]  resolution,
  output logic        ok,
  output logic        final_res,
  output logic [15:0] port_number,
  output logic        secure_scheme
);
  import ubfc_pkg::*;

  logic          s1_valid;
  logic [7:0]    s1_char;
  logic          s1_last;
  ubfc_state_t   state;
  ubfc_state_t   state_next;
  ubfc_result_t  step_res;
  logic          advance;

  // Move the held beat into the result register when it is free
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  ubfc_step u_step (
    .st      (state),
    .c       (s1_char),
    .last    (s1_last),
    .st_next (state_next),
    .result  (step_res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_char <= char_in;
      s1_last <= end_of_url;
    end
  end

  // Parser state advances once per classified beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      char_out      <= s1_char;
      part          <= step_res.part;
      resolution    <= step_res.res;
      ok            <= step_res.ok;
      final_res     <= s1_last;
      port_number   <= step_res.port;
      secure_scheme <= step_res.sec;
    end
  end

endmodule

// ===== rtl/ubfc_checker.sv =====
// Port-level checks for the URL byte field classifier, bound to the top level.
`timescale 1ns / 1ps
module ubfc_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  char_out,
  input logic [3:0]  part,
  input logic [2:0]  resolution,
  input logic        ok,
  input logic        final_res,
  input logic [15:0] port_number,
  input logic        secure_scheme
);
  import ubfc_pkg::*;

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(char_out) && $stable(part)
      && $stable(ok) && $stable(final_res) && $stable(port_number))
    else $error("result beat changed while stalled");

  // Drop tags once the URL is invalid
  a_invalid_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> part == PART_SCHEME && resolution == RES_NONE
      && port_number == 16'd0 && !secure_scheme)
    else $error("invalid beat carries tags or port");

  // Report port and scheme only on the last byte
  a_nonfinal_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !final_res |-> port_number == 16'd0 && !secure_scheme)
    else $error("port or scheme reported before the last byte");

  // Keep codes in range
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> part <= PART_FRAG && resolution <= RES_USER_PASS)
    else $error("part or resolution code out of range");

  // Flag a secure scheme only on a valid last byte
  a_secure_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && secure_scheme |-> ok && final_res)
    else $error("secure scheme flagged on a non-final or invalid beat");

endmodule

bind url_byte_field_classifier ubfc_checker u_ubfc_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .char_out      (char_out),
  .part          (part),
  .resolution    (resolution),
  .ok            (ok),
  .final_res     (final_res),
  .port_number   (port_number),
  .secure_scheme (secure_scheme)
);
